@@ src/mce_pkg.sv @@
// ----------------------------------------------------------------------------
// Morse encoder package
// Symbol codes, the decoded sequence type and the Morse code table shared by
// the lookup stage, the serializer and the top level.
// ----------------------------------------------------------------------------
package mce_pkg;

    // Most results a single character can produce ('$': seven symbols plus a space).
    localparam int MaxResults = 8;
    localparam int CountW     = $clog2(MaxResults + 1);
    localparam int MaxSymbols = MaxResults - 1;
    localparam int SymLenW    = $clog2(MaxSymbols + 1);
    localparam int SymIdxW    = $clog2(MaxSymbols);

    localparam logic [7:0] AsciiDot   = 8'h2E;
    localparam logic [7:0] AsciiDash  = 8'h2D;
    localparam logic [7:0] AsciiSpace = 8'h20;
    localparam logic [7:0] AsciiSlash = 8'h2F;

    typedef enum logic [1:0] {
        SYM_DOT,
        SYM_DASH,
        SYM_SPACE,
        SYM_SLASH
    } sym_t;

    // A fully decoded character: number of results and the symbols in order,
    // first symbol in entry zero.
    typedef struct packed {
        logic [CountW-1:0]        count;
        sym_t [MaxResults-1:0]    syms;
    } seq_t;

    // Morse code of one character. Pattern bits: 1 is a dash, 0 is a dot,
    // the first symbol sits at bit len-1.
    typedef struct packed {
        logic                     valid;
        logic [SymLenW-1:0]       len;
        logic [MaxSymbols-1:0]    pat;
    } morse_t;

    // Status the serializer reports to the top level.
    typedef struct packed {
        logic busy;
        logic finishing;
    } ser_status_t;

    function automatic morse_t char_to_morse(input logic [7:0] ch);
        logic [7:0] up;
        morse_t     m;
        up = ch;
        if (ch >= "a" && ch <= "z") begin
            up = ch - 8'h20;
        end
        m = '{valid: 1'b1, len: '0, pat: '0};
        case (up)
            "A": begin m.len = 3'd2; m.pat = 7'b0000001; end
            "B": begin m.len = 3'd4; m.pat = 7'b0001000; end
            "C": begin m.len = 3'd4; m.pat = 7'b0001010; end
            "D": begin m.len = 3'd3; m.pat = 7'b0000100; end
            "E": begin m.len = 3'd1; m.pat = 7'b0000000; end
            "F": begin m.len = 3'd4; m.pat = 7'b0000010; end
            "G": begin m.len = 3'd3; m.pat = 7'b0000110; end
            "H": begin m.len = 3'd4; m.pat = 7'b0000000; end
            "I": begin m.len = 3'd2; m.pat = 7'b0000000; end
            "J": begin m.len = 3'd4; m.pat = 7'b0000111; end
            "K": begin m.len = 3'd3; m.pat = 7'b0000101; end
            "L": begin m.len = 3'd4; m.pat = 7'b0000100; end
            "M": begin m.len = 3'd2; m.pat = 7'b0000011; end
            "N": begin m.len = 3'd2; m.pat = 7'b0000010; end
            "O": begin m.len = 3'd3; m.pat = 7'b0000111; end
            "P": begin m.len = 3'd4; m.pat = 7'b0000110; end
            "Q": begin m.len = 3'd4; m.pat = 7'b0001101; end
            "R": begin m.len = 3'd3; m.pat = 7'b0000010; end
            "S": begin m.len = 3'd3; m.pat = 7'b0000000; end
            "T": begin m.len = 3'd1; m.pat = 7'b0000001; end
            "U": begin m.len = 3'd3; m.pat = 7'b0000001; end
            "V": begin m.len = 3'd4; m.pat = 7'b0000001; end
            "W": begin m.len = 3'd3; m.pat = 7'b0000011; end
            "X": begin m.len = 3'd4; m.pat = 7'b0001001; end
            "Y": begin m.len = 3'd4; m.pat = 7'b0001011; end
            "Z": begin m.len = 3'd4; m.pat = 7'b0001100; end
            "0": begin m.len = 3'd5; m.pat = 7'b0011111; end
            "1": begin m.len = 3'd5; m.pat = 7'b0001111; end
            "2": begin m.len = 3'd5; m.pat = 7'b0000111; end
            "3": begin m.len = 3'd5; m.pat = 7'b0000011; end
            "4": begin m.len = 3'd5; m.pat = 7'b0000001; end
            "5": begin m.len = 3'd5; m.pat = 7'b0000000; end
            "6": begin m.len = 3'd5; m.pat = 7'b0010000; end
            "7": begin m.len = 3'd5; m.pat = 7'b0011000; end
            "8": begin m.len = 3'd5; m.pat = 7'b0011100; end
            "9": begin m.len = 3'd5; m.pat = 7'b0011110; end
            ".": begin m.len = 3'd6; m.pat = 7'b0010101; end
            ",": begin m.len = 3'd6; m.pat = 7'b0110011; end
            "?": begin m.len = 3'd6; m.pat = 7'b0001100; end
            "!": begin m.len = 3'd6; m.pat = 7'b0101011; end
            "-": begin m.len = 3'd6; m.pat = 7'b0100001; end
            "/": begin m.len = 3'd5; m.pat = 7'b0010010; end
            "(": begin m.len = 3'd5; m.pat = 7'b0010110; end
            ")": begin m.len = 3'd6; m.pat = 7'b0101101; end
            "\"": begin m.len = 3'd6; m.pat = 7'b0010010; end
            "$": begin m.len = 3'd7; m.pat = 7'b0001001; end
            "@": begin m.len = 3'd6; m.pat = 7'b0011010; end
            default: begin m.valid = 1'b0; end
        endcase
        return m;
    endfunction

    function automatic logic [7:0] sym_to_ascii(input sym_t s);
        logic [7:0] c;
        unique case (s)
            SYM_DOT:   c = AsciiDot;
            SYM_DASH:  c = AsciiDash;
            SYM_SPACE: c = AsciiSpace;
            SYM_SLASH: c = AsciiSlash;
            default:   c = AsciiSpace;
        endcase
        return c;
    endfunction

endpackage

@@ src/morse_character_encoder.sv @@
// ----------------------------------------------------------------------------
// Morse character encoder
// Encodes ASCII characters into International Morse code symbols, one output
// symbol per transaction, with the final symbol of each character flagged.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake            | Payload
//   --------+----------------------+------------------------------------
//   input   | in_valid / in_ready  | in_char (8 bits)
//   output  | out_valid / out_ready| out_char (8 bits), last (1 bit)
//
// A character produces from zero to eight output transactions, one per cycle
// while out_ready is high; the output serializer sets the rate at which the
// input accepts characters. Characters with no Morse code are consumed and
// produce nothing. Reset clears the holding stage and the serializer; no output
// is valid after it. A stall on the output holds the current symbol; the input
// keeps taking one further character into the holding stage meanwhile.
//
// Structure: the lookup decodes an accepted character straight into the
// holding register; the serializer loads from it when it is empty or when
// its final symbol is being taken, so symbols of consecutive characters
// flow without a gap.
module morse_character_encoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       last
);
    import mce_pkg::*;

    seq_t        lookup_seq;
    seq_t        hold_seq_reg;
    seq_t        hold_seq_next;
    logic        hold_valid_reg;
    logic        hold_valid_next;
    logic        accept;
    logic        load;
    ser_status_t ser_status;

    mce_lookup u_lookup (
        .in_char (in_char),
        .seq     (lookup_seq)
    );

    // The serializer takes the held sequence when it is idle, or in the same
    // cycle its last symbol leaves, so the next character follows directly.
    assign load = hold_valid_reg &&
                  (!ser_status.busy || (ser_status.finishing && out_ready));

    // The holding stage frees up in the same cycle it hands its sequence on.
    assign in_ready = !hold_valid_reg || load;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_seq_next   = hold_seq_reg;
        if (accept)
        begin
            // Characters without a code leave nothing to send.
            hold_valid_next = (lookup_seq.count != '0);
            hold_seq_next   = lookup_seq;
        end
        else if (load)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_seq_reg <= hold_seq_next;
    end

    mce_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .seq       (hold_seq_reg),
        .status    (ser_status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last      (last)
    );

endmodule

@@ src/mce_lookup.sv @@
// ----------------------------------------------------------------------------
// Morse encoder lookup
// Turns one ASCII character into its full sequence of output symbols.
// ----------------------------------------------------------------------------
module mce_lookup (
    input  logic [7:0]    in_char,
    output mce_pkg::seq_t seq
);
    import mce_pkg::*;

    morse_t              code;
    logic [SymIdxW-1:0]  idx;

    assign code = char_to_morse(in_char);

    always_comb
    begin
        seq.count = '0;
        idx       = '0;
        for (int i = 0; i < MaxResults; i++)
        begin
            seq.syms[i] = SYM_SPACE;
        end
        if (in_char == AsciiSpace)
        begin
            // A word gap is written as space, slash, space.
            seq.count   = CountW'(3);
            seq.syms[1] = SYM_SLASH;
        end
        else if (code.valid)
        begin
            seq.count = CountW'(code.len) + CountW'(1);
            for (int i = 0; i < MaxSymbols; i++)
            begin
                if (SymLenW'(i) < code.len)
                begin
                    idx         = SymIdxW'(code.len - SymLenW'(i) - SymLenW'(1));
                    seq.syms[i] = code.pat[idx] ? SYM_DASH : SYM_DOT;
                end
            end
        end
    end

endmodule

@@ src/mce_serializer.sv @@
// ----------------------------------------------------------------------------
// Morse encoder serializer
// Holds one decoded sequence and presents its symbols one per transaction.
// ----------------------------------------------------------------------------
module mce_serializer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  mce_pkg::seq_t       seq,
    output mce_pkg::ser_status_t status,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_char,
    output logic                last
);
    import mce_pkg::*;

    logic [CountW-1:0]      count_reg;
    logic [CountW-1:0]      count_next;
    sym_t [MaxResults-1:0]  syms_reg;
    sym_t [MaxResults-1:0]  syms_next;
    logic                   advance;

    assign out_valid = (count_reg != '0);
    assign last      = (count_reg == CountW'(1));
    assign out_char  = sym_to_ascii(syms_reg[0]);
    assign advance   = out_valid && out_ready;

    assign status.busy      = out_valid;
    assign status.finishing = last;

    always_comb
    begin
        count_next = count_reg;
        syms_next  = syms_reg;
        if (load)
        begin
            count_next = seq.count;
            syms_next  = seq.syms;
        end
        else if (advance)
        begin
            count_next = count_reg - CountW'(1);
            for (int i = 0; i < MaxResults - 1; i++)
            begin
                syms_next[i] = syms_reg[i + 1];
            end
            syms_next[MaxResults-1] = SYM_SPACE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        syms_reg <= syms_next;
    end

endmodule

@@ src/mce_checker.sv @@
// ----------------------------------------------------------------------------
// Morse encoder checker
// Port-level assertions on both channels of the Morse character encoder.
// ----------------------------------------------------------------------------
module mce_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] in_char,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       last
);
    import mce_pkg::*;

    // A waiting input transaction stays offered with its character unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_char))
        else $error("input payload changed while waiting");

    // A stalled output transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last))
        else $error("output payload changed while stalled");

    // Only the four Morse symbol characters appear on the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_char == AsciiDot) || (out_char == AsciiDash) ||
                      (out_char == AsciiSpace) || (out_char == AsciiSlash))
        else $error("illegal output symbol");

    // Every character ends with a space.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> out_char == AsciiSpace)
        else $error("final symbol is not a space");

    // A slash is never the final symbol of its character, and more output follows it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_char == AsciiSlash |-> !last ##1 out_valid)
        else $error("word gap cut short");

endmodule

bind morse_character_encoder mce_checker u_mce_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_char   (in_char),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .last      (last)
);

@@ sim/morse_encoder_checker.sv @@
// ----------------------------------------------------------------------------
// Morse encoder checker
// Watches both channels of the encoder, predicts the Morse symbols of every
// accepted character and compares each output transaction with the oldest
// symbol still due. Reports a running failure count to the testbench top.
// ----------------------------------------------------------------------------
module morse_encoder_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_char,
    input  logic       last,
    output int         errors,
    output int         pending,
    output int         chars_taken,
    output int         silent_chars,
    output int         symbols_checked
);

    localparam int MaxReports = 20;

    typedef struct packed {
        logic [7:0] sym;
        logic       fin;
    } morse_symbol_t;

    morse_symbol_t symbols_due[$];

    // Full output text of one character, trailing separator included.
    // An empty string means the character is dropped silently.
    function automatic string morse_for(input logic [7:0] ch);
        logic [7:0] up;
        string      code;
        up = (ch >= "a" && ch <= "z") ? ch - 8'h20 : ch;
        case (up)
            "A": code = ".-";
            "B": code = "-...";
            "C": code = "-.-.";
            "D": code = "-..";
            "E": code = ".";
            "F": code = "..-.";
            "G": code = "--.";
            "H": code = "....";
            "I": code = "..";
            "J": code = ".---";
            "K": code = "-.-";
            "L": code = ".-..";
            "M": code = "--";
            "N": code = "-.";
            "O": code = "---";
            "P": code = ".--.";
            "Q": code = "--.-";
            "R": code = ".-.";
            "S": code = "...";
            "T": code = "-";
            "U": code = "..-";
            "V": code = "...-";
            "W": code = ".--";
            "X": code = "-..-";
            "Y": code = "-.--";
            "Z": code = "--..";
            "0": code = "-----";
            "1": code = ".----";
            "2": code = "..---";
            "3": code = "...--";
            "4": code = "....-";
            "5": code = ".....";
            "6": code = "-....";
            "7": code = "--...";
            "8": code = "---..";
            "9": code = "----.";
            ".": code = ".-.-.-";
            ",": code = "--..--";
            "?": code = "..--..";
            "!": code = "-.-.--";
            "-": code = "-....-";
            "/": code = "-..-.";
            "(": code = "-.--.";
            ")": code = "-.--.-";
            "\"": code = ".-..-.";
            "$": code = "...-..-";
            "@": code = ".--.-.";
            " ": return " / ";
            default: return "";
        endcase
        return {code, " "};
    endfunction

    task automatic flag_mismatch(input string what, input string want, input string got);
        errors++;
        if (errors <= MaxReports)
        begin
            $display("%0t: %s: expected %s, actual %s", $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        morse_symbol_t due;
        string         seq;
        if (!rst_n)
        begin
            symbols_due.delete();
            errors          = 0;
            chars_taken     = 0;
            silent_chars    = 0;
            symbols_checked = 0;
            pending        <= 0;
        end
        else
        begin
            // Results are compared before the new character is queued; the
            // encoder cannot answer a character in the cycle it takes it.
            if (out_valid && out_ready)
            begin
                symbols_checked++;
                if (symbols_due.size() == 0)
                begin
                    flag_mismatch("unexpected symbol", "nothing",
                                  $sformatf("0x%02h last %0b", out_char, last));
                end
                else
                begin
                    due = symbols_due.pop_front();
                    if (out_char !== due.sym)
                    begin
                        flag_mismatch("out_char", $sformatf("0x%02h", due.sym),
                                      $sformatf("0x%02h", out_char));
                    end
                    if (last !== due.fin)
                    begin
                        flag_mismatch("last", $sformatf("%0b", due.fin),
                                      $sformatf("%0b", last));
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                seq = morse_for(in_char);
                chars_taken++;
                if (seq.len() == 0)
                begin
                    silent_chars++;
                end
                for (int i = 0; i < seq.len(); i++)
                begin
                    symbols_due.push_back('{sym: seq[i], fin: (i == seq.len() - 1)});
                end
            end
            pending <= symbols_due.size();
        end
    end

endmodule

@@ sim/tb_morse_character_encoder.sv @@
// ----------------------------------------------------------------------------
// Morse character encoder testbench
// Drives characters into the encoder under varying handshake pressure and
// lets a checker beside the block predict and compare every output symbol.
// ----------------------------------------------------------------------------
module tb_morse_character_encoder;

    // Length of the deliberate output hold-off, long enough for the encoder
    // to fill its holding stage and push back on the input.
    localparam int LongStall = 60;
    // Cycles allowed after the last expected symbol for stray output to show.
    localparam int TailCycles = 16;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic [7:0] in_char      = 8'h00;
    logic       out_ready    = 1'b0;
    logic       stall_toggle = 1'b0;
    logic       stall_seen   = 1'b0;
    int         stall_left   = 0;
    int         recv_idle_pct = 0;
    int         send_idle_pct = 0;

    logic       in_ready;
    logic       out_valid;
    logic [7:0] out_char;
    logic       last;

    int errors;
    int pending;
    int chars_taken;
    int silent_chars;
    int symbols_checked;

    always #5 clk = ~clk;

    morse_character_encoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_char   (in_char),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last      (last)
    );

    morse_encoder_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_char         (in_char),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_char        (out_char),
        .last            (last),
        .errors          (errors),
        .pending         (pending),
        .chars_taken     (chars_taken),
        .silent_chars    (silent_chars),
        .symbols_checked (symbols_checked)
    );

    // Output side. The ready line is redrawn every cycle from the current
    // idle percentage. A toggle on stall_toggle starts a long hold-off that
    // this process counts down on its own, so the stimulus can keep offering
    // characters while the output stays blocked.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
            stall_seen <= 1'b0;
        end
        else if (stall_toggle != stall_seen)
        begin
            stall_seen <= stall_toggle;
            stall_left <= LongStall;
            out_ready  <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offers one character and returns at the edge where it is accepted.
    // Valid is left high so a following character can be presented at once
    // without the line dropping; idle cycles, if any, lower it first.
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_char  <= c;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    // Stops offering and waits until every predicted symbol has been seen.
    // The first edge lets the checker count the character just accepted.
    task automatic drain_symbols();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Mostly encodable characters, lower case included, and about one in
    // five arbitrary bytes so that the silently dropped ones mix in.
    function automatic logic [7:0] pick_char();
        string encodable;
        encodable = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789.,?!-/()\"$@ ";
        if ($urandom_range(99) < 20)
        begin
            return 8'($urandom_range(255));
        end
        return encodable[$urandom_range(encodable.len() - 1)];
    endfunction

    initial
    begin : stimulus
        string directed;
        // Every letter case, both ends of the digits, the space separator, the
        // longest code, every punctuation mark and the bytes just outside the
        // encodable ranges.
        directed = "AzaZ09 $.,?!-/()\"@~`{";

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed characters with no idling on either side.
        recv_idle_pct <= 0;
        send_idle_pct  = 0;
        for (int i = 0; i < directed.len(); i++)
        begin
            send_char(directed[i]);
        end
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h80);
        send_char(8'h7F);
        drain_symbols();

        // Sender mostly busy, receiver mostly idle: the output is the
        // bottleneck and the encoder spends most cycles stalled.
        send_idle_pct  = 12;
        recv_idle_pct <= 81;
        repeat (130)
        begin
            send_char(pick_char());
        end
        // The sender pauses here until every symbol is out.
        drain_symbols();

        // Sender mostly idle, receiver mostly ready: the encoder runs dry.
        send_idle_pct  = 81;
        recv_idle_pct <= 12;
        repeat (130)
        begin
            send_char(pick_char());
        end
        drain_symbols();

        // Full rate on both sides, with one long output hold-off in the
        // middle while the sender keeps offering characters.
        send_idle_pct  = 0;
        recv_idle_pct <= 0;
        repeat (50)
        begin
            send_char(pick_char());
        end
        stall_toggle <= ~stall_toggle;
        repeat (90)
        begin
            send_char(pick_char());
        end

        drain_symbols();
        repeat (TailCycles) @(posedge clk);

        $display("Encoded %0d characters (%0d with no Morse code) and checked %0d symbols",
                 chars_taken, silent_chars, symbols_checked);
        $display("under both idling mixes, full rate and a %0d-cycle output hold-off",
                 LongStall);
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of this stimulus.
    initial
    begin
        #4000000;
        $display("Timeout with %0d symbols still due", pending);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
